// ===== design/bwss_pkg.sv =====
// Shared types, constants and pin decode functions for the bus write snooper.
package bwss_pkg;

    localparam int MEMORY_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(MEMORY_DEPTH);
    localparam int Q_DEPTH      = 3;
    localparam int QP_W         = $clog2(Q_DEPTH);
    localparam int QC_W         = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] low_pins;
        logic [7:0]  high_pins;
        logic [9:0]  read_address;
    } in_item_t;

    typedef struct packed {
        logic        write_done;
        logic [9:0]  write_address;
        logic [7:0]  write_data;
        logic [31:0] write_total;
        logic [7:0]  read_data;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic pin_clock(logic [7:0] hi);
        return hi[7];
    endfunction

    function automatic logic pin_wren(logic [31:0] lo);
        return lo[5];
    endfunction

    function automatic logic [9:0] pin_address(logic [31:0] lo, logic [7:0] hi);
        return {hi[4:0], lo[27:25], lo[23:22]};
    endfunction

    function automatic logic [7:0] pin_data(logic [31:0] lo);
        return {lo[21], lo[19:13]};
    endfunction

    function automatic logic [ADDR_W-1:0] mem_index(logic [9:0] a);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/bus_write_snooper_shadow_ram.sv =====
// Top level of the bus write snooper with its shadow memory.
//
// Input channel (s_valid/s_ready/s_item): one item per bus pin snapshot, or a
// read of one shadow memory byte. Result channel (m_valid/m_ready/m_item):
// exactly one result item per input item, in order.
// A pin sample that sees the bus clock fall after a captured write stores the
// held byte and reports it with write_done set; write_total always carries
// the write counter after the item. A read item returns the shadow byte.
// Path: an accepted item goes to the result stage register, then to the result queue.
// Throughput: one item per cycle while s_ready is high, set by the single shadow RAM
// write port and its registered read; the snoop state updates in the accept cycle,
// so back-to-back samples and reads need no interlock.
// Reset: aresetn low clears the snoop state and the write counter; after it,
// a clearing pass writes 0xFF to all 1024 shadow entries, one per cycle, and
// s_ready stays low until that pass is done.
// Stall: a three-entry result queue absorbs items in flight; after the clearing
// pass, s_ready drops only when the queue and the result stage together hold three items.
module bus_write_snooper_shadow_ram
    import bwss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic            accept;
    logic            init_done;
    mem_req_t        mem_req;
    logic            st_vld;
    logic            st_read;
    out_item_t       st_item;
    out_item_t       push_item;
    logic [7:0]      ram_rdata;
    logic            can_take;
    logic [QC_W-1:0] q_level;

    assign s_ready = init_done && can_take;
    assign accept  = s_valid && s_ready;

    bwss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_item),
        .init_done (init_done),
        .mem_req   (mem_req),
        .st_vld    (st_vld),
        .st_read   (st_read),
        .st_item   (st_item)
    );

    bwss_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_DEPTH)
    ) u_shadow (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        push_item           = st_item;
        push_item.read_data = st_read ? ram_rdata : 8'd0;
    end

    bwss_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (st_vld),
        .push_item (push_item),
        .inflight  (st_vld),
        .can_take  (can_take),
        .level     (q_level),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

`ifndef SYNTHESIS
    a_bounded_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, q_level} + (QC_W + 1)'(st_vld)) <= (QC_W + 1)'(Q_DEPTH))
        else $error("more items in flight than the result queue holds");
`endif

endmodule

// ===== design/bwss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bwss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/bwss_ctrl.sv =====
// Snoop state machine, write counter, memory clearing pass and result stage.
module bwss_ctrl
    import bwss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  in_item_t  item,
    output logic      init_done,
    output mem_req_t  mem_req,
    output logic      st_vld,
    output logic      st_read,
    output out_item_t st_item
);

    typedef enum logic [1:0] {
        PH_WAIT_HIGH = 2'd0,
        PH_WAIT_LOW  = 2'd1,
        PH_CAPTURE   = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [9:0]        held_addr_reg, held_addr_next;
    logic [7:0]        held_data_reg, held_data_next;
    logic [31:0]       count_reg, count_next;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              st_vld_reg;
    logic              st_read_reg;
    out_item_t         st_item_reg, st_item_next;
    logic              wr_fire;
    logic              clk_pin;
    logic              is_sample;

    assign clk_pin   = pin_clock(item.high_pins);
    assign is_sample = accept && (item.kind == KIND_SAMPLE);

    always_comb begin
        phase_next     = phase_reg;
        held_addr_next = held_addr_reg;
        held_data_next = held_data_reg;
        count_next     = count_reg;
        wr_fire        = 1'b0;
        if (is_sample) begin
            case (phase_reg)
                PH_WAIT_LOW: begin
                    if (!clk_pin) begin
                        phase_next = PH_WAIT_HIGH;
                    end
                end
                PH_CAPTURE: begin
                    if (clk_pin) begin
                        held_addr_next = pin_address(item.low_pins, item.high_pins);
                        held_data_next = pin_data(item.low_pins);
                    end else begin
                        wr_fire    = 1'b1;
                        count_next = count_reg + 32'd1;
                        phase_next = PH_WAIT_HIGH;
                    end
                end
                default: begin
                    phase_next = PH_WAIT_HIGH;
                    if (clk_pin) begin
                        if (pin_wren(item.low_pins)) begin
                            held_addr_next = pin_address(item.low_pins, item.high_pins);
                            held_data_next = pin_data(item.low_pins);
                            phase_next     = PH_CAPTURE;
                        end else begin
                            phase_next = PH_WAIT_LOW;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        st_item_next               = '0;
        st_item_next.write_done    = wr_fire;
        st_item_next.write_address = wr_fire ? held_addr_reg : 10'd0;
        st_item_next.write_data    = wr_fire ? held_data_reg : 8'd0;
        st_item_next.write_total   = count_next;
    end

    always_comb begin
        mem_req.re    = accept && (item.kind == KIND_READ);
        mem_req.raddr = mem_index(item.read_address);
        if (clr_busy_reg) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_addr_reg;
            mem_req.wdata = ERASED_BYTE;
        end else begin
            mem_req.we    = wr_fire;
            mem_req.waddr = mem_index(held_addr_reg);
            mem_req.wdata = held_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT_HIGH;
            held_addr_reg <= '0;
            held_data_reg <= '0;
            count_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            st_vld_reg    <= 1'b0;
            st_read_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            held_addr_reg <= held_addr_next;
            held_data_reg <= held_data_next;
            count_reg     <= count_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MEMORY_DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            st_vld_reg  <= accept;
            st_read_reg <= accept && (item.kind == KIND_READ);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_item_reg <= st_item_next;
        end
    end

    assign init_done = !clr_busy_reg;
    assign st_vld    = st_vld_reg;
    assign st_read   = st_read_reg;
    assign st_item   = st_item_reg;

`ifndef SYNTHESIS
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_fire |=> count_reg == $past(count_reg) + 32'd1)
        else $error("write counter did not step on a completed write");
    a_quiet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !st_vld_reg && !wr_fire)
        else $error("item in flight during clearing pass");
`endif

endmodule

// ===== design/bwss_outq.sv =====
// Three-entry result queue that decouples the result channel from the pipeline.
module bwss_outq
    import bwss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      inflight,
    output logic      can_take,
    output logic [QC_W-1:0] level,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    out_item_t       q_mem [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic            pop;
    logic [QC_W:0]   load;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_item  = q_mem[rd_ptr_reg];
    assign level   = count_reg;
    assign load    = {1'b0, count_reg} + (QC_W + 1)'(inflight);
    assign can_take = (load < (QC_W + 1)'(Q_DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QC_W'(push) - QC_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg != QC_W'(Q_DEPTH))
        else $error("result queue overflow");
`endif

endmodule
